@@ rtl/core/mbrtu_pkg.sv @@
// Types, codes and the CRC-16 byte step of the Modbus RTU holding register slave.
// No dependencies; the interfaces and the top level import it.
package mbrtu_pkg;

  localparam int unsigned BufDepth = 256;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // item kinds
  localparam logic [2:0] KIND_RX    = 3'd0;
  localparam logic [2:0] KIND_GAP   = 3'd1;
  localparam logic [2:0] KIND_PULL  = 3'd2;
  localparam logic [2:0] KIND_HREAD = 3'd3;
  localparam logic [2:0] KIND_HWRITE = 3'd4;

  // Modbus function codes
  localparam logic [7:0] FN_READ  = 8'h03;
  localparam logic [7:0] FN_WRITE = 8'h10;
  localparam logic [7:0] FN_EXC   = 8'h80;

  // exception codes
  localparam logic [7:0] EXC_FUNCTION = 8'd1;
  localparam logic [7:0] EXC_ADDRESS  = 8'd2;
  localparam logic [7:0] EXC_VALUE    = 8'd3;

  // frame status
  localparam logic [2:0] FS_SERVED   = 3'd0;
  localparam logic [2:0] FS_NOT_OURS = 3'd1;
  localparam logic [2:0] FS_TIMEOUT  = 3'd2;
  localparam logic [2:0] FS_CRC_ERR  = 3'd3;
  localparam logic [2:0] FS_BAD_FN   = 3'd4;
  localparam logic [2:0] FS_BAD_ADDR = 3'd5;
  localparam logic [2:0] FS_BAD_VAL  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_REG_COUNT  = 2'd1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  rx_byte;
    logic [5:0]  host_index;
    logic [15:0] host_data;
  } req_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        status_valid;
    logic [2:0]  frame_status;
    logic [15:0] host_read_data;
  } rsp_t;

  typedef struct packed {
    logic [1:0] index;
    logic [7:0] value;
  } cfg_t;

  // one byte of CRC-16/Modbus, reflected
  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
    end
    return x;
  endfunction

endpackage

@@ rtl/core/mbrtu_ifs.sv @@
// Valid/ready channel interfaces: item input, result output, register writes.
// Depends on mbrtu_pkg.
interface mbrtu_req_if import mbrtu_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mbrtu_rsp_if import mbrtu_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mbrtu_cfg_if import mbrtu_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/modbus_rtu_holding_register_slave.sv @@
// Modbus RTU slave for function codes 03 and 16 with a holding register table.
// Depends on mbrtu_pkg and the channel interfaces in mbrtu_ifs.sv.
//
// Usage: every item on req_i (rx byte, line gap, tx pull, host read, host write)
// gives exactly one transaction on rsp_o. Register writes on cfg_i are always
// taken and must only be issued while the block is idle.
// Flow: simple items pass ST_EXEC, then ST_TX or ST_HRD where needed, and ST_DONE
// loads the output register. The byte that ends a frame runs the CRC check, one
// buffered byte per cycle through the shared CRC unit, then the table work (ST_WRA,
// ST_WRB, ST_WRC for each register) and the reply build (header, register bytes,
// two CRC bytes). One item is worked at a time; req_i is not ready meanwhile.
// Reset: a clearing pass writes zero to all TABLE_DEPTH registers, one per
// cycle, before the first item is taken. Parser and reply queue start empty.
// Stall: a result waits in the output register; the next item is accepted, but
// its result is held back until rsp_o has taken the earlier one.
module modbus_rtu_holding_register_slave import mbrtu_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = 256,
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mbrtu_req_if.sink      req_i,
  mbrtu_rsp_if.source    rsp_o,
  mbrtu_cfg_if.sink      cfg_i
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [9:0]  MaxFrame = 10'(MAX_FRAME_BYTES);
  localparam logic [16:0] TableDepth = 17'(TABLE_DEPTH);
  localparam logic [AW-1:0] LastEntry = AW'(TABLE_DEPTH - 1);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_PARSE, ST_CHK, ST_SERVE, ST_WRA, ST_WRB, ST_WRC,
    ST_RSP, ST_RDREG, ST_RDHI, ST_RDLO, ST_CRCLO, ST_CRCHI, ST_TX, ST_HRD, ST_DONE
  } state_e;

  typedef enum logic [1:0] {PH_FUNCTION, PH_META, PH_DATA, PH_SPARE} phase_e;
  typedef enum logic [1:0] {RM_EXC, RM_READ, RM_WRITE} rmode_e;

  state_e          state_q;
  phase_e          phase_q;
  rmode_e          rmode_q;
  req_t            item_q;
  rsp_t            res_q, out_q;
  logic            out_valid_q;
  logic [7:0]      slave_addr_q;
  logic [6:0]      reg_count_q;
  logic [8:0]      rx_idx_q, rem_q, rptr_q, rsp_len_q, send_pos_q;
  logic            discard_q, chk_v_q;
  logic [7:0]      hdr_q [7];
  logic [7:0]      exc_addr_q, exc_fn_q, exc_code_q, hi_q, wpos_q;
  logic [15:0]     crc_q;
  logic [AW-1:0]   hptr_q, clr_q;
  logic [6:0]      cnt_q;

  // memories
  logic [7:0]  req_mem [BufDepth];
  logic [7:0]  rsp_mem [BufDepth];
  logic [15:0] hreg_mem [TABLE_DEPTH];
  logic [7:0]  req_rd_q, rsp_rd_q;
  logic [15:0] hreg_rd_q;

  logic            req_we, rsp_we, hreg_we;
  logic [7:0]      rsp_wdata, crc_in;
  logic [AW-1:0]   hreg_waddr, hreg_raddr;
  logic [15:0]     hreg_wdata, crc_next;
  logic            hidx_ok, ours, rsp_hdr_last;
  logic [15:0]     start_w, qty_w;
  logic [16:0]     limit_w, end_w;
  logic [9:0]      meta_rem;
  logic [8:0]      rem_dec;
  logic            out_load;

  assign start_w  = {hdr_q[2], hdr_q[3]};
  assign qty_w    = {hdr_q[4], hdr_q[5]};
  assign end_w    = {1'b0, start_w} + {1'b0, qty_w};
  assign limit_w  = (17'(reg_count_q) < TableDepth) ? 17'(reg_count_q) : TableDepth;
  assign hidx_ok  = ({11'b0, item_q.host_index} < TableDepth);
  assign ours     = (hdr_q[0] == slave_addr_q) || (hdr_q[0] == 8'h00);
  assign meta_rem = 10'd2 + ((hdr_q[1] == FN_WRITE) ? {2'b0, hdr_q[6]} : 10'd0);
  assign rem_dec  = (rem_q != 9'd0) ? rem_q - 9'd1 : 9'd0;
  assign rsp_hdr_last = (rmode_q == RM_WRITE) ? (wpos_q == 8'd5) : (wpos_q == 8'd2);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);

  // reply byte source
  always_comb begin
    rsp_wdata = 8'h00;
    unique case (state_q)
      ST_RSP: begin
        unique case (rmode_q)
          RM_EXC: begin
            if (wpos_q == 8'd0) rsp_wdata = exc_addr_q;
            else if (wpos_q == 8'd1) rsp_wdata = exc_fn_q + FN_EXC;
            else rsp_wdata = exc_code_q;
          end
          RM_READ: begin
            if (wpos_q == 8'd0) rsp_wdata = hdr_q[0];
            else if (wpos_q == 8'd1) rsp_wdata = hdr_q[1];
            else rsp_wdata = {hdr_q[5][6:0], 1'b0};
          end
          default: rsp_wdata = hdr_q[3'(wpos_q)];
        endcase
      end
      ST_RDHI:  rsp_wdata = hreg_rd_q[15:8];
      ST_RDLO:  rsp_wdata = hreg_rd_q[7:0];
      ST_CRCLO: rsp_wdata = crc_q[7:0];
      ST_CRCHI: rsp_wdata = crc_q[15:8];
      default:  rsp_wdata = 8'h00;
    endcase
  end

  // shared CRC unit
  assign crc_in   = (state_q == ST_CHK) ? req_rd_q : rsp_wdata;
  assign crc_next = crc_byte(crc_q, crc_in);

  assign req_we = (state_q == ST_EXEC) && (item_q.kind == KIND_RX) && !discard_q
                  && ({1'b0, rx_idx_q} < MaxFrame);
  assign rsp_we = (state_q == ST_RSP) || (state_q == ST_RDHI) || (state_q == ST_RDLO)
                  || (state_q == ST_CRCLO) || (state_q == ST_CRCHI);

  always_comb begin
    hreg_we    = 1'b0;
    hreg_waddr = hptr_q;
    hreg_wdata = {hi_q, req_rd_q};
    if (state_q == ST_CLEAR) begin
      hreg_we    = 1'b1;
      hreg_waddr = clr_q;
      hreg_wdata = 16'h0000;
    end else if (state_q == ST_EXEC) begin
      hreg_we    = (item_q.kind == KIND_HWRITE) && hidx_ok;
      hreg_waddr = AW'(item_q.host_index);
      hreg_wdata = item_q.host_data;
    end else if (state_q == ST_WRC) begin
      hreg_we = 1'b1;
    end
  end

  assign hreg_raddr = (state_q == ST_EXEC) ? AW'(item_q.host_index) : hptr_q;

  always_ff @(posedge clk_i) begin
    if (req_we) req_mem[rx_idx_q[7:0]] <= item_q.rx_byte;
    req_rd_q <= req_mem[rptr_q[7:0]];
  end

  always_ff @(posedge clk_i) begin
    if (rsp_we) rsp_mem[wpos_q] <= rsp_wdata;
    rsp_rd_q <= rsp_mem[send_pos_q[7:0]];
  end

  always_ff @(posedge clk_i) begin
    if (hreg_we) hreg_mem[hreg_waddr] <= hreg_wdata;
    hreg_rd_q <= hreg_mem[hreg_raddr];
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      phase_q      <= PH_FUNCTION;
      rmode_q      <= RM_EXC;
      item_q       <= '0;
      res_q        <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
      slave_addr_q <= 8'd1;
      reg_count_q  <= 7'd64;
      rx_idx_q     <= '0;
      rem_q        <= 9'd2;
      rptr_q       <= '0;
      rsp_len_q    <= '0;
      send_pos_q   <= '0;
      discard_q    <= 1'b0;
      chk_v_q      <= 1'b0;
      for (int i = 0; i < 7; i++) hdr_q[i] <= '0;
      exc_addr_q   <= '0;
      exc_fn_q     <= '0;
      exc_code_q   <= '0;
      hi_q         <= '0;
      wpos_q       <= '0;
      crc_q        <= CrcInit;
      hptr_q       <= '0;
      clr_q        <= '0;
      cnt_q        <= '0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.data.index == CFG_SLAVE_ADDR) slave_addr_q <= cfg_i.data.value;
        else if (cfg_i.data.index == CFG_REG_COUNT) reg_count_q <= cfg_i.data.value[6:0];
      end

      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && rsp_o.ready) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == LastEntry) state_q <= ST_IDLE;
        end

        ST_IDLE: begin
          if (req_i.valid) begin
            item_q  <= req_i.data;
            res_q   <= '0;
            state_q <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          state_q <= ST_DONE;
          unique case (item_q.kind)
            KIND_RX: begin
              if (!discard_q) begin
                if ({1'b0, rx_idx_q} >= MaxFrame) begin
                  rx_idx_q <= '0;
                  rem_q <= 9'd2;
                  phase_q <= PH_FUNCTION;
                  discard_q <= 1'b1;
                  res_q.status_valid <= 1'b1;
                  res_q.frame_status <= FS_BAD_VAL;
                end else begin
                  rx_idx_q <= rx_idx_q + 9'd1;
                  if (rx_idx_q < 9'd7) hdr_q[rx_idx_q[2:0]] <= item_q.rx_byte;
                  rem_q <= rem_dec;
                  if (rem_dec == 9'd0) state_q <= ST_PARSE;
                end
              end
            end
            KIND_GAP: begin
              if (!discard_q && rx_idx_q != 9'd0) begin
                res_q.status_valid <= 1'b1;
                res_q.frame_status <= FS_TIMEOUT;
              end
              discard_q <= 1'b0;
              rx_idx_q <= '0;
              rem_q <= 9'd2;
              phase_q <= PH_FUNCTION;
            end
            KIND_PULL: begin
              if (send_pos_q < rsp_len_q) state_q <= ST_TX;
            end
            KIND_HREAD: begin
              if (hidx_ok) state_q <= ST_HRD;
            end
            default: ;
          endcase
        end

        ST_TX: begin
          res_q.tx_valid <= 1'b1;
          res_q.tx_byte  <= rsp_rd_q;
          if (send_pos_q + 9'd1 >= rsp_len_q) begin
            res_q.tx_last <= 1'b1;
            rsp_len_q <= '0;
            send_pos_q <= '0;
          end else begin
            send_pos_q <= send_pos_q + 9'd1;
          end
          state_q <= ST_DONE;
        end

        ST_HRD: begin
          res_q.host_read_data <= hreg_rd_q;
          state_q <= ST_DONE;
        end

        ST_PARSE: begin
          state_q <= ST_DONE;
          if (!ours) begin
            rx_idx_q <= '0;
            rem_q <= 9'd2;
            phase_q <= PH_FUNCTION;
            discard_q <= 1'b1;
            res_q.status_valid <= 1'b1;
            res_q.frame_status <= FS_NOT_OURS;
          end else if (phase_q == PH_META) begin
            if ({1'b0, rx_idx_q} + meta_rem > MaxFrame) begin
              rx_idx_q <= '0;
              rem_q <= 9'd2;
              phase_q <= PH_FUNCTION;
              discard_q <= 1'b1;
              res_q.status_valid <= 1'b1;
              res_q.frame_status <= FS_BAD_VAL;
              exc_addr_q <= slave_addr_q;
              exc_fn_q <= hdr_q[1];
              exc_code_q <= EXC_VALUE;
              rmode_q <= RM_EXC;
              crc_q <= CrcInit;
              wpos_q <= '0;
              state_q <= ST_RSP;
            end else begin
              rem_q <= meta_rem[8:0];
              phase_q <= PH_DATA;
            end
          end else if (phase_q == PH_DATA) begin
            rptr_q <= '0;
            chk_v_q <= 1'b0;
            crc_q <= CrcInit;
            state_q <= ST_CHK;
          end else if (hdr_q[1] == FN_READ) begin
            rem_q <= 9'd4;
            phase_q <= PH_META;
          end else if (hdr_q[1] == FN_WRITE) begin
            rem_q <= 9'd5;
            phase_q <= PH_META;
          end else begin
            rx_idx_q <= '0;
            rem_q <= 9'd2;
            phase_q <= PH_FUNCTION;
            discard_q <= 1'b1;
            res_q.status_valid <= 1'b1;
            res_q.frame_status <= FS_BAD_FN;
            exc_addr_q <= slave_addr_q;
            exc_fn_q <= hdr_q[1];
            exc_code_q <= EXC_FUNCTION;
            rmode_q <= RM_EXC;
            crc_q <= CrcInit;
            wpos_q <= '0;
            state_q <= ST_RSP;
          end
        end

        // request CRC; each byte is folded in the cycle after its buffer read
        ST_CHK: begin
          if (chk_v_q) crc_q <= crc_next;
          if (rptr_q != rx_idx_q) begin
            rptr_q <= rptr_q + 9'd1;
            chk_v_q <= 1'b1;
          end else begin
            chk_v_q <= 1'b0;
            if (!chk_v_q) state_q <= ST_SERVE;
          end
        end

        ST_SERVE: begin
          rx_idx_q <= '0;
          rem_q <= 9'd2;
          phase_q <= PH_FUNCTION;
          res_q.status_valid <= 1'b1;
          exc_addr_q <= hdr_q[0];
          exc_fn_q <= hdr_q[1];
          hptr_q <= AW'(start_w);
          cnt_q <= qty_w[6:0];
          wpos_q <= '0;
          rmode_q <= RM_EXC;
          if (crc_q != 16'h0000) begin
            res_q.frame_status <= FS_CRC_ERR;
            state_q <= ST_DONE;
          end else if (end_w > limit_w) begin
            res_q.frame_status <= FS_BAD_ADDR;
            exc_code_q <= EXC_ADDRESS;
            crc_q <= CrcInit;
            state_q <= ST_RSP;
          end else if (hdr_q[1] == FN_READ) begin
            crc_q <= CrcInit;
            state_q <= ST_RSP;
            if (qty_w > 16'd125
                || 18'd5 + {1'b0, qty_w, 1'b0} > 18'(MAX_FRAME_BYTES)) begin
              res_q.frame_status <= FS_BAD_VAL;
              exc_code_q <= EXC_VALUE;
            end else begin
              res_q.frame_status <= FS_SERVED;
              rmode_q <= RM_READ;
            end
          end else if ({9'b0, hdr_q[6]} != {qty_w, 1'b0}) begin
            res_q.frame_status <= FS_BAD_VAL;
            exc_code_q <= EXC_VALUE;
            crc_q <= CrcInit;
            state_q <= ST_RSP;
          end else begin
            res_q.frame_status <= FS_SERVED;
            rmode_q <= RM_WRITE;
            rptr_q <= 9'd7;
            crc_q <= CrcInit;
            state_q <= (qty_w == 16'd0) ? ST_RSP : ST_WRA;
          end
        end

        ST_WRA: begin
          rptr_q <= rptr_q + 9'd1;
          state_q <= ST_WRB;
        end

        ST_WRB: begin
          hi_q <= req_rd_q;
          rptr_q <= rptr_q + 9'd1;
          state_q <= ST_WRC;
        end

        ST_WRC: begin
          hptr_q <= hptr_q + AW'(1);
          cnt_q <= cnt_q - 7'd1;
          state_q <= (cnt_q == 7'd1) ? ST_RSP : ST_WRA;
        end

        ST_RSP: begin
          crc_q <= crc_next;
          wpos_q <= wpos_q + 8'd1;
          if (rsp_hdr_last) begin
            state_q <= (rmode_q == RM_READ && cnt_q != 7'd0) ? ST_RDREG : ST_CRCLO;
          end
        end

        ST_RDREG: state_q <= ST_RDHI;

        ST_RDHI: begin
          crc_q <= crc_next;
          wpos_q <= wpos_q + 8'd1;
          state_q <= ST_RDLO;
        end

        ST_RDLO: begin
          crc_q <= crc_next;
          wpos_q <= wpos_q + 8'd1;
          hptr_q <= hptr_q + AW'(1);
          cnt_q <= cnt_q - 7'd1;
          state_q <= (cnt_q == 7'd1) ? ST_CRCLO : ST_RDREG;
        end

        ST_CRCLO: begin
          wpos_q <= wpos_q + 8'd1;
          state_q <= ST_CRCHI;
        end

        ST_CRCHI: begin
          rsp_len_q <= {1'b0, wpos_q} + 9'd1;
          send_pos_q <= '0;
          state_q <= ST_DONE;
        end

        ST_DONE: begin
          if (out_load) begin
            out_q <= res_q;
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_last_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.tx_last |-> rsp_o.data.tx_valid)
    else $error("tx_last without tx_valid");

  a_send_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_pos_q <= rsp_len_q)
    else $error("send position beyond queued reply");

  a_chk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHK |-> rptr_q <= rx_idx_q)
    else $error("CRC walk past received bytes");

  a_one_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.data.status_valid |-> !rsp_o.data.tx_valid
      && rsp_o.data.frame_status != 3'd7)
    else $error("malformed status result");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("second item taken while busy");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for modbus_rtu_holding_register_slave: framed Modbus requests,
// line gaps, tx pulls and host accesses, with a built-in slave predictor.
// Depends on mbrtu_pkg, mbrtu_ifs.sv and the top level RTL.

class mb_scoreboard;
  mbrtu_pkg::rsp_t pending_q[$];
  int unsigned n_bad;
  int unsigned n_checked;

  function void note_item(mbrtu_pkg::rsp_t e);
    pending_q.push_back(e);
  endfunction

  function void check_result(mbrtu_pkg::rsp_t got);
    mbrtu_pkg::rsp_t e;
    if (pending_q.size() == 0) begin
      n_bad++;
      if (n_bad <= 10) $display("unexpected result %h", got);
      return;
    end
    e = pending_q.pop_front();
    n_checked++;
    if (got !== e) begin
      n_bad++;
      if (n_bad <= 10) begin
        $display("mismatch #%0d: exp txv=%0d txb=%h txl=%0d sv=%0d fs=%0d hr=%h",
                 n_checked, e.tx_valid, e.tx_byte, e.tx_last, e.status_valid,
                 e.frame_status, e.host_read_data);
        $display("             got txv=%0d txb=%h txl=%0d sv=%0d fs=%0d hr=%h",
                 got.tx_valid, got.tx_byte, got.tx_last, got.status_valid,
                 got.frame_status, got.host_read_data);
      end
    end
  endfunction
endclass

module tb;
  import mbrtu_pkg::*;

  localparam int MaxFrame = 256;
  localparam int TblDepth = 64;
  localparam int WatchLimit = 20000;

  typedef enum logic [1:0] {PH_FN, PH_META, PH_DATA} phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mbrtu_req_if req_if ();
  mbrtu_rsp_if rsp_if ();
  mbrtu_cfg_if cfg_if ();

  modbus_rtu_holding_register_slave u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source),
    .cfg_i (cfg_if.sink)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  own_addr;
  logic [6:0]  reg_count;
  logic [7:0]  rq_buf [256];
  int unsigned rx_idx, rx_left;
  phase_e      phase;
  bit          dropping;
  logic [7:0]  reply_buf [256];
  int unsigned reply_len, send_pos;
  logic [15:0] regs [TblDepth];

  mb_scoreboard sb;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned quiet_cycles;
  int unsigned n_items, n_frames;
  bit timed_out;

  function automatic logic [15:0] crc16(ref logic [7:0] p[256], input int unsigned n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n && i < 256; i++) begin
      c ^= {8'h00, p[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void seal_reply(int unsigned len);
    logic [15:0] c;
    c = crc16(reply_buf, len);
    reply_buf[len & 8'hFF] = c[7:0];
    reply_buf[(len + 1) & 8'hFF] = c[15:8];
    reply_len = len + 2;
    send_pos = 0;
  endfunction

  function automatic void put_exception(logic [7:0] a, logic [7:0] fn, logic [7:0] code);
    reply_buf[0] = a;
    reply_buf[1] = fn + FN_EXC;
    reply_buf[2] = code;
    seal_reply(3);
  endfunction

  function automatic void parser_restart();
    rx_idx = 0;
    rx_left = 2;
    phase = PH_FN;
  endfunction

  function automatic int finish_frame();
    logic [7:0] a, fn;
    int unsigned start, qty, lim, n;
    a = rq_buf[0];
    fn = rq_buf[1];
    start = {rq_buf[2], rq_buf[3]};
    qty = {rq_buf[4], rq_buf[5]};
    lim = reg_count < TblDepth ? reg_count : TblDepth;
    if (crc16(rq_buf, rx_idx) != 0) return FS_CRC_ERR;
    if (start + qty > lim) begin
      put_exception(a, fn, EXC_ADDRESS);
      return FS_BAD_ADDR;
    end
    if (fn == FN_READ) begin
      if (qty > 125 || 5 + 2 * qty > MaxFrame) begin
        put_exception(a, fn, EXC_VALUE);
        return FS_BAD_VAL;
      end
      reply_buf[0] = a;
      reply_buf[1] = fn;
      reply_buf[2] = 8'((qty << 1) & 8'hFF);
      n = 3;
      for (int i = start; i < start + qty && i < TblDepth; i++) begin
        reply_buf[n++] = regs[i][15:8];
        reply_buf[n++] = regs[i][7:0];
      end
      seal_reply(n);
      return FS_SERVED;
    end
    if (rq_buf[6] != 2 * qty) begin
      put_exception(a, fn, EXC_VALUE);
      return FS_BAD_VAL;
    end
    for (int i = 0; i < qty && start + i < TblDepth; i++) begin
      if (8 + 2 * i >= 256) break;
      regs[start + i] = {rq_buf[7 + 2 * i], rq_buf[8 + 2 * i]};
    end
    for (int i = 0; i < 6; i++) reply_buf[i] = rq_buf[i];
    seal_reply(6);
    return FS_SERVED;
  endfunction

  function automatic int take_rx(logic [7:0] b);
    logic [7:0] fn;
    int st;
    if (dropping) return -1;
    if (rx_idx >= MaxFrame) begin
      parser_restart();
      dropping = 1;
      return FS_BAD_VAL;
    end
    rq_buf[rx_idx] = b;
    rx_idx++;
    if (rx_left > 0) rx_left--;
    if (rx_left != 0) return -1;
    if (rq_buf[0] != own_addr && rq_buf[0] != 0) begin
      parser_restart();
      dropping = 1;
      return FS_NOT_OURS;
    end
    fn = rq_buf[1];
    if (phase == PH_META) begin
      rx_left = 2;
      if (fn == FN_WRITE) rx_left += rq_buf[6];
      if (rx_idx + rx_left > MaxFrame) begin
        put_exception(own_addr, fn, EXC_VALUE);
        parser_restart();
        dropping = 1;
        return FS_BAD_VAL;
      end
      phase = PH_DATA;
      return -1;
    end
    if (phase == PH_DATA) begin
      st = finish_frame();
      parser_restart();
      return st;
    end
    if (fn == FN_READ) rx_left = 4;
    else if (fn == FN_WRITE) rx_left = 5;
    else begin
      put_exception(own_addr, fn, EXC_FUNCTION);
      parser_restart();
      dropping = 1;
      return FS_BAD_FN;
    end
    phase = PH_META;
    return -1;
  endfunction

  function automatic rsp_t predict_item(req_t it);
    rsp_t r;
    int st;
    r = '0;
    st = -1;
    case (it.kind)
      KIND_RX: st = take_rx(it.rx_byte);
      KIND_GAP: begin
        if (!dropping && rx_idx != 0) st = FS_TIMEOUT;
        dropping = 0;
        parser_restart();
      end
      KIND_PULL: begin
        if (send_pos < reply_len) begin
          r.tx_valid = 1'b1;
          r.tx_byte = reply_buf[send_pos];
          send_pos++;
          if (send_pos >= reply_len) begin
            r.tx_last = 1'b1;
            reply_len = 0;
            send_pos = 0;
          end
        end
      end
      KIND_HREAD: r.host_read_data = regs[it.host_index];
      KIND_HWRITE: regs[it.host_index] = it.host_data;
      default: ;
    endcase
    if (st >= 0) begin
      r.status_valid = 1'b1;
      r.frame_status = 3'(st);
    end
    return r;
  endfunction

  // drivers; valid stays up between back-to-back items and drops while idling
  task automatic send_item(req_t it);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= it;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_item(predict_item(it));
    n_items++;
  endtask

  task automatic rx(logic [7:0] b);
    req_t it;
    it = '0;
    it.kind = KIND_RX;
    it.rx_byte = b;
    send_item(it);
  endtask

  task automatic plain(logic [2:0] k, logic [5:0] idx = 0, logic [15:0] d = 0);
    req_t it;
    it.kind = k;
    it.rx_byte = 8'($urandom);
    it.host_index = idx;
    it.host_data = d;
    send_item(it);
  endtask

  // frame with correct CRC unless bad_crc, then a gap in three of four cases and up to 12 pulls
  task automatic frame(logic [7:0] a, logic [7:0] fn, int unsigned start, int unsigned qty,
                       int wr_bytes, bit bad_crc);
    logic [7:0] f [256];
    logic [15:0] c;
    int unsigned n;
    f[0] = a; f[1] = fn;
    f[2] = 8'(start >> 8); f[3] = 8'(start);
    f[4] = 8'(qty >> 8); f[5] = 8'(qty);
    n = 6;
    if (fn == FN_WRITE) begin
      f[6] = 8'(wr_bytes);
      n = 7;
      for (int i = 0; i < wr_bytes && n < 254; i++) f[n++] = 8'($urandom);
    end
    c = crc16(f, n);
    if (bad_crc) c ^= 16'(1 << $urandom_range(15));
    f[n] = c[7:0]; f[n + 1] = c[15:8];
    for (int i = 0; i < n + 2; i++) rx(f[i]);
    n_frames++;
    if ($urandom_range(3) != 0) plain(KIND_GAP);
    for (int i = 0; i < $urandom_range(12); i++) plain(KIND_PULL);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, value: v};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_SLAVE_ADDR) own_addr = v;
    else reg_count = v[6:0];
    @(posedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic random_burst(int unsigned count);
    int unsigned cnt;
    int unsigned lim;
    for (int k = 0; k < count; k++) begin
      lim = reg_count < TblDepth ? reg_count : TblDepth;
      case ($urandom_range(9))
        0, 1, 2: begin
          cnt = $urandom_range(1, 8);
          frame($urandom_range(3) == 0 ? 8'd0 : own_addr, FN_READ,
                $urandom_range(lim), cnt, 0, $urandom_range(9) == 0);
        end
        3, 4: begin
          cnt = $urandom_range(1, 6);
          frame($urandom_range(5) == 0 ? 8'd0 : own_addr, FN_WRITE,
                $urandom_range(lim), cnt,
                $urandom_range(7) == 0 ? $urandom_range(12) : 2 * cnt,
                $urandom_range(9) == 0);
        end
        5: plain(KIND_HWRITE, 6'($urandom), 16'($urandom));
        6: plain(KIND_HREAD, 6'($urandom));
        7: begin
          repeat ($urandom_range(1, 6)) rx(8'($urandom));
          plain(KIND_GAP);
        end
        8: plain(3'($urandom_range(1, 7)));
        default: plain(KIND_PULL);
      endcase
    end
  endtask

  // result side
  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.data);
    rsp_if.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
        || (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (quiet_cycles > WatchLimit + 2 * TblDepth && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired, %0d results outstanding", sb.pending_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    sb = new();
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    send_idle_pct = 38;
    recv_idle_pct = 87;
    quiet_cycles = 0;
    timed_out = 0;
    own_addr = 8'd1;
    reg_count = 7'd64;
    for (int i = 0; i < TblDepth; i++) regs[i] = '0;
    for (int i = 0; i < 256; i++) begin
      rq_buf[i] = '0;
      reply_buf[i] = '0;
    end
    parser_restart();
    dropping = 0;
    reply_len = 0;
    send_pos = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and each special case
    write_cfg(CFG_SLAVE_ADDR, 8'd247);
    write_cfg(CFG_REG_COUNT, 8'd64);
    plain(KIND_PULL);                                   // nothing queued
    plain(KIND_HWRITE, 6'd63, 16'hFFFF);
    plain(KIND_HWRITE, 6'd0, 16'h0000);
    plain(KIND_HREAD, 6'd63);
    frame(8'd247, FN_READ, 62, 2, 0, 0);
    frame(8'd0, FN_WRITE, 0, 2, 4, 0);                  // broadcast
    frame(8'd247, FN_READ, 0, 126, 0, 0);               // address check wins
    frame(8'd9, FN_READ, 0, 1, 0, 0);                   // another slave
    frame(8'd247, 8'h07, 0, 1, 0, 0);                   // illegal function
    frame(8'd247, FN_READ, 0, 1, 0, 1);                 // corrupted CRC
    frame(8'd247, FN_WRITE, 0, 2, 3, 0);                // byte count mismatch
    rx(8'd247); rx(FN_READ); plain(KIND_GAP);           // truncated frame
    plain(KIND_GAP);                                    // idle gap
    plain(3'd7);
    drain();

    write_cfg(CFG_SLAVE_ADDR, 8'd1);
    write_cfg(CFG_REG_COUNT, 8'd0);
    frame(8'd1, FN_READ, 0, 1, 0, 0);                   // empty table
    frame(8'd1, FN_READ, 16'hFFFF, 16'hFFFF, 0, 0);
    // byte count too large for the buffer, then a byte while discarding
    rx(8'd1); rx(FN_WRITE); repeat (4) rx(8'h00); rx(8'hFF); rx(8'h55);
    plain(KIND_GAP);
    repeat (8) plain(KIND_PULL);
    drain();

    write_cfg(CFG_REG_COUNT, 8'd127);
    random_burst(10);
    drain();
    send_idle_pct = 87;
    recv_idle_pct = 38;
    write_cfg(CFG_SLAVE_ADDR, 8'($urandom_range(1, 247)));
    write_cfg(CFG_REG_COUNT, 8'($urandom_range(8, 64)));
    random_burst(10);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_cfg(CFG_REG_COUNT, 8'd64);
    random_burst(10);
    drain();

    $display("%0d items, %0d frames, %0d results checked, %0d mismatches",
             n_items, n_frames, sb.n_checked, sb.n_bad);
    if (sb.n_bad == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/mbrtu_pkg.sv
rtl/core/mbrtu_ifs.sv
rtl/core/modbus_rtu_holding_register_slave.sv
verif/tb.sv
